>>> hdl/aes256_cfb8_byte_cipher_assert.svh
// Assertion macros shared by the checker of the CFB8 byte cipher.
// No dependencies; included by files that assert.
`ifndef AES256_CFB8_BYTE_CIPHER_ASSERT_SVH
`define AES256_CFB8_BYTE_CIPHER_ASSERT_SVH

// Condition a implies condition b in the same cycle.
`define ACB_ASSERT_NOW(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("acb check failed");

// Condition a implies condition b in the next cycle.
`define ACB_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("acb check failed");

`endif

>>> hdl/acb_pkg.sv
// Package of the AES-256 CFB8 byte cipher: beat types, register indexes,
// S-box table and round functions. No dependencies.
`default_nettype none
package acb_pkg;

   localparam int ROUNDS = 14;
   localparam int RK_W   = $clog2(ROUNDS + 1);

   typedef enum logic [2:0] {
      REG_KEY0 = 3'd0,
      REG_KEY1 = 3'd1,
      REG_KEY2 = 3'd2,
      REG_KEY3 = 3'd3,
      REG_IVH  = 3'd4,
      REG_IVL  = 3'd5,
      REG_MODE = 3'd6
   } csr_reg_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_in_buffer;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       status;
      logic       last_out;
   } rsp_type;

   localparam logic [7:0] RCON_INIT = 8'h01;
   localparam logic [7:0] GF_POLY   = 8'h1b;

   localparam logic [2047:0] SBOX_BITS = {
      256'h637c777bf26b6fc53001672bfed7ab76ca82c97dfa5947f0add4a2af9ca472c0,
      256'hb7fd9326363ff7cc34a5e5f171d8311504c723c31896059a071280e2eb27b275,
      256'h09832c1a1b6e5aa0523bd6b329e32f8453d100ed20fcb15b6acbbe394a4c58cf,
      256'hd0efaafb434d338545f9027f503c9fa851a3408f929d38f5bcb6da2110fff3d2,
      256'hcd0c13ec5f974417c4a77e3d645d197360814fdc222a908846eeb814de5e0bdb,
      256'he0323a0a4906245cc2d3ac629195e479e7c8376d8dd54ea96c56f4ea657aae08,
      256'hba78252e1ca6b4c6e8dd741f4bbd8b8a703eb5664803f60e613557b986c11d9e,
      256'he1f8981169d98e949b1e87e9ce5528df8ca1890dbfe6426841992d0fb054bb16
   };

   function automatic logic [7:0] acb_sbox(input logic [7:0] b);
      logic [10:0] pos;
      pos = 11'd2047 - {b, 3'b000};
      return SBOX_BITS[pos -: 8];
   endfunction

   function automatic logic [7:0] acb_gf_double(input logic [7:0] v);
      return {v[6:0], 1'b0} ^ (v[7] ? GF_POLY : 8'h00);
   endfunction

   function automatic logic [31:0] acb_sub_word(input logic [31:0] w);
      return {acb_sbox(w[31:24]), acb_sbox(w[23:16]), acb_sbox(w[15:8]), acb_sbox(w[7:0])};
   endfunction

   // Byte k of the block sits in bits 127-8k down to 120-8k.
   function automatic logic [127:0] acb_sub_shift(input logic [127:0] s);
      logic [127:0] t;
      t = '0;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[127 - 8 * (c * 4 + r) -: 8] = acb_sbox(s[127 - 8 * (((c + r) % 4) * 4 + r) -: 8]);
         end
      end
      return t;
   endfunction

   function automatic logic [127:0] acb_mix(input logic [127:0] s);
      logic [127:0] t;
      logic [7:0]   a, b, d2, d3, all;
      t = '0;
      for (int c = 0; c < 4; c++) begin
         a   = s[127 - 32 * c -: 8];
         b   = s[119 - 32 * c -: 8];
         d2  = s[111 - 32 * c -: 8];
         d3  = s[103 - 32 * c -: 8];
         all = a ^ b ^ d2 ^ d3;
         t[127 - 32 * c -: 8] = a ^ all ^ acb_gf_double(a ^ b);
         t[119 - 32 * c -: 8] = b ^ all ^ acb_gf_double(b ^ d2);
         t[111 - 32 * c -: 8] = d2 ^ all ^ acb_gf_double(d2 ^ d3);
         t[103 - 32 * c -: 8] = d3 ^ all ^ acb_gf_double(d3 ^ a);
      end
      return t;
   endfunction

endpackage
`default_nettype wire

>>> hdl/aes256_cfb8_byte_cipher.sv
// AES-256 CFB8 byte cipher: one shared round unit under a small sequencer.
// Depends on acb_pkg.
//
// Usage: write the key (registers 0..3) and IV (4, 5) on the csr_ port; each
// key or IV write reloads the feedback register from the IV and expands the
// key, one round key per cycle; during the expansion csr_ready and the
// input are held off. Register 6 selects decrypt and takes effect at once.
// Bytes enter on req_ (valid/stall) and results leave on rsp_ (valid/stall).
// A byte's first key addition happens at the accepting edge, the rounds then
// go through the single round unit in ST_ROUND, and ST_FINISH loads the
// output register. The next byte is taken only back in ST_IDLE, so the block
// takes no new byte before it is through with the last.
// The output register holds its beat while rsp_stall is high; the block
// still accepts a new byte then and waits in its last step until the
// register frees. Before any key or IV write a byte goes straight to ST_FINISH
// and gives status 1 and out_byte 0; the feedback register is left unchanged.
// Reset is synchronous and active high; it clears the key, IV, mode and
// keyed flag. The round keys stay undefined until the first key or IV write.
`default_nettype none
module aes256_cfb8_byte_cipher import acb_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output      logic          req_stall,
   input  wire req_type       req_data,
   output      logic          rsp_valid,
   input  wire logic          rsp_stall,
   output      rsp_type       rsp_data,
   input  wire logic          csr_valid,
   output      logic          csr_ready,
   input  wire logic [2:0]    csr_index,
   input  wire logic [63:0]   csr_wdata
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_EXPAND = 4'b0010,
      ST_ROUND  = 4'b0100,
      ST_FINISH = 4'b1000
   } fsm_type;

   fsm_type          fsm_ff, fsm_in;
   logic [RK_W-1:0]  round_ff, round_in;
   logic [RK_W-1:0]  ek_ff, ek_in;
   logic [127:0]     state_ff, state_in;
   logic [255:0]     win_ff, win_in;
   logic [7:0]       rcon_ff, rcon_in;
   logic [127:0]     fb_ff, fb_in;
   logic             keyed_ff, keyed_in;
   logic             err_ff, err_in;
   req_type          din_ff, din_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;
   logic [255:0]     key_ff, key_in;
   logic [127:0]     iv_ff, iv_in;
   logic             mode_ff, mode_in;
   logic [127:0]     rkey_ff [ROUNDS+1];

   logic             csr_wr, req_acc, key_load, rk_we;
   logic [31:0]      t_word, sub_in, sub_out;
   logic [31:0]      n0, n1, n2, n3;
   logic [127:0]     sb, mixed, rnd;
   logic [7:0]       out_byte;

   assign csr_ready = (fsm_ff == ST_IDLE);
   assign req_stall = (fsm_ff != ST_IDLE) | csr_valid;
   assign csr_wr    = csr_valid & csr_ready;
   assign req_acc   = req_valid & ~req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Key schedule step: four new words from the eight-word window.
   always_comb begin
      t_word  = win_ff[31:0];
      sub_in  = ek_ff[0] ? t_word : {t_word[23:0], t_word[31:24]};
      sub_out = acb_sub_word(sub_in) ^ (ek_ff[0] ? 32'h0 : {rcon_ff, 24'h0});
      n0 = win_ff[255:224] ^ sub_out;
      n1 = win_ff[223:192] ^ n0;
      n2 = win_ff[191:160] ^ n1;
      n3 = win_ff[159:128] ^ n2;
   end

   // Shared round unit; the final round skips the column mix.
   always_comb begin
      sb    = acb_sub_shift(state_ff);
      mixed = acb_mix(sb);
      rnd   = (round_ff == RK_W'(ROUNDS)) ? sb : mixed;
   end

   assign out_byte = state_ff[127:120] ^ din_ff.data_byte;

   always_comb begin
      fsm_in       = fsm_ff;
      round_in     = round_ff;
      ek_in        = ek_ff;
      state_in     = state_ff;
      win_in       = win_ff;
      rcon_in      = rcon_ff;
      fb_in        = fb_ff;
      keyed_in     = keyed_ff;
      err_in       = err_ff;
      din_in       = din_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_in       = rsp_ff;
      key_in       = key_ff;
      iv_in        = iv_ff;
      mode_in      = mode_ff;
      key_load     = 1'b0;
      rk_we        = 1'b0;
      case (fsm_ff)
         ST_IDLE: begin
            if (csr_wr) begin
               case (csr_index)
                  REG_KEY0: key_in[255:192] = csr_wdata;
                  REG_KEY1: key_in[191:128] = csr_wdata;
                  REG_KEY2: key_in[127:64]  = csr_wdata;
                  REG_KEY3: key_in[63:0]    = csr_wdata;
                  REG_IVH:  iv_in[127:64]   = csr_wdata;
                  REG_IVL:  iv_in[63:0]     = csr_wdata;
                  REG_MODE: mode_in         = csr_wdata[0];
                  default:  ;
               endcase
               if (csr_index inside {REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3,
                                     REG_IVH, REG_IVL}) begin
                  key_load = 1'b1;
                  fb_in    = iv_in;
                  keyed_in = 1'b1;
                  win_in   = key_in;
                  rcon_in  = RCON_INIT;
                  ek_in    = RK_W'(2);
                  fsm_in   = ST_EXPAND;
               end
            end else if (req_acc) begin
               din_in = req_data;
               if (keyed_ff) begin
                  state_in = fb_ff ^ rkey_ff[0];
                  round_in = RK_W'(1);
                  err_in   = 1'b0;
                  fsm_in   = ST_ROUND;
               end else begin
                  err_in = 1'b1;
                  fsm_in = ST_FINISH;
               end
            end
         end
         ST_EXPAND: begin
            rk_we  = 1'b1;
            win_in = {win_ff[127:0], n0, n1, n2, n3};
            if (!ek_ff[0]) begin
               rcon_in = acb_gf_double(rcon_ff);
            end
            if (ek_ff == RK_W'(ROUNDS)) begin
               fsm_in = ST_IDLE;
            end else begin
               ek_in = ek_ff + 1'b1;
            end
         end
         ST_ROUND: begin
            state_in = rnd ^ rkey_ff[round_ff];
            if (round_ff == RK_W'(ROUNDS)) begin
               fsm_in = ST_FINISH;
            end else begin
               round_in = round_ff + 1'b1;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in    = 1'b1;
               rsp_in.out_byte = err_ff ? 8'h00 : out_byte;
               rsp_in.status   = err_ff;
               rsp_in.last_out = din_ff.last_in_buffer;
               if (!err_ff) begin
                  fb_in = {fb_ff[119:0], mode_ff ? din_ff.data_byte : out_byte};
               end
               fsm_in = ST_IDLE;
            end
         end
         default: fsm_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff       <= ST_IDLE;
         keyed_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fb_ff        <= '0;
         key_ff       <= '0;
         iv_ff        <= '0;
         mode_ff      <= 1'b0;
      end else begin
         fsm_ff       <= fsm_in;
         keyed_ff     <= keyed_in;
         rsp_valid_ff <= rsp_valid_in;
         fb_ff        <= fb_in;
         key_ff       <= key_in;
         iv_ff        <= iv_in;
         mode_ff      <= mode_in;
      end
   end

   always_ff @(posedge clock) begin
      round_ff <= round_in;
      ek_ff    <= ek_in;
      state_ff <= state_in;
      win_ff   <= win_in;
      rcon_ff  <= rcon_in;
      err_ff   <= err_in;
      din_ff   <= din_in;
      rsp_ff   <= rsp_in;
      if (key_load) begin
         rkey_ff[0] <= key_in[255:128];
         rkey_ff[1] <= key_in[127:0];
      end else if (rk_we) begin
         rkey_ff[ek_ff] <= {n0, n1, n2, n3};
      end
   end

endmodule
`default_nettype wire

>>> hdl/acb_checker.sv
// Port-level checker for the AES-256 CFB8 byte cipher, bound to the top level.
// Depends on acb_pkg and aes256_cfb8_byte_cipher_assert.svh.
`default_nettype none
`include "aes256_cfb8_byte_cipher_assert.svh"
module acb_checker import acb_pkg::*; (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire rsp_type     rsp_data,
   input wire logic        csr_valid,
   input wire logic        csr_ready,
   input wire logic [2:0]  csr_index
);

   // A stalled result beat stays put.
   `ACB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // One byte at a time: after an accepted beat the input is held off.
   `ACB_ASSERT_NEXT(a_req_busy, clock, reset, req_valid && !req_stall, req_stall && !csr_ready)

   // An error beat never carries keystream.
   `ACB_ASSERT_NOW(a_err_zero, clock, reset, rsp_valid && rsp_data.status, rsp_data.out_byte == 8'h00)

   // A key or IV write starts the key expansion, which blocks both ports.
   `ACB_ASSERT_NEXT(a_rekey_busy, clock, reset, csr_valid && csr_ready && csr_index <= REG_IVL, req_stall && !csr_ready)

endmodule

bind aes256_cfb8_byte_cipher acb_checker u_acb_checker (.*);
`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench of the AES-256 CFB8 byte cipher: a local AES-256 CFB8
// model predicts each result beat, and a scoreboard class checks them in order.
// Depends on acb_pkg and the aes256_cfb8_byte_cipher RTL.
`timescale 1ns / 100ps
`default_nettype none
module tb;
   import acb_pkg::*;

   logic          clock;
   logic          reset;
   logic          req_valid;
   logic          req_stall;
   req_type       req_data;
   logic          rsp_valid;
   logic          rsp_stall;
   rsp_type       rsp_data;
   logic          csr_valid;
   logic          csr_ready;
   logic [2:0]    csr_index;
   logic [63:0]   csr_wdata;

   int            error_count;
   int            mode_idle_pct;
   int            mode_stall_pct;
   bit            long_hold;
   int            bytes_sent;

   aes256_cfb8_byte_cipher u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // Local cipher model: its own copy of the registers, round keys and feedback.
   class cfb8_scoreboard;
      logic [63:0] key_reg [4];
      logic [63:0] iv_hi, iv_lo;
      bit          decrypting;
      bit          keyed;
      logic [31:0] rk [60];
      logic [7:0]  fb [16];
      rsp_type     pending [$];

      function void clear();
         foreach (key_reg[i]) key_reg[i] = '0;
         iv_hi = '0; iv_lo = '0; decrypting = 0; keyed = 0;
         foreach (fb[i]) fb[i] = '0;
         foreach (rk[i]) rk[i] = '0;
         pending.delete();
      endfunction

      function logic [7:0] sb(input logic [7:0] b);
         return SBOX_BITS[2047 - 8 * b -: 8];
      endfunction

      function logic [7:0] dbl(input logic [7:0] v);
         return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
      endfunction

      function logic [31:0] subw(input logic [31:0] w);
         return {sb(w[31:24]), sb(w[23:16]), sb(w[15:8]), sb(w[7:0])};
      endfunction

      function void expand_key();
         logic [31:0] t;
         logic [7:0]  rc;
         rc = 8'h01;
         for (int i = 0; i < 8; i++)
            rk[i] = (i % 2 == 0) ? key_reg[i / 2][63:32] : key_reg[i / 2][31:0];
         for (int i = 8; i < 60; i++) begin
            t = rk[i - 1];
            if (i % 8 == 0) begin
               t = subw({t[23:0], t[31:24]}) ^ {rc, 24'h0};
               rc = dbl(rc);
            end else if (i % 8 == 4) begin
               t = subw(t);
            end
            rk[i] = rk[i - 8] ^ t;
         end
         for (int i = 0; i < 8; i++) begin
            fb[i]     = iv_hi[63 - 8 * i -: 8];
            fb[8 + i] = iv_lo[63 - 8 * i -: 8];
         end
         keyed = 1;
      endfunction

      function void write_reg(input csr_reg_type idx, input logic [63:0] v);
         case (idx)
            REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: begin
               key_reg[idx] = v; expand_key();
            end
            REG_IVH: begin
               iv_hi = v; expand_key();
            end
            REG_IVL: begin
               iv_lo = v; expand_key();
            end
            REG_MODE: decrypting = v[0];
            default: ;
         endcase
      endfunction

      function logic [7:0] keystream();
         logic [7:0] s [16];
         logic [7:0] t [16];
         logic [7:0] a, b, c2, c3, all;
         foreach (s[i]) s[i] = fb[i];
         for (int r = 0; r <= 14; r++) begin
            if (r > 0) begin
               for (int c = 0; c < 4; c++)
                  for (int w = 0; w < 4; w++)
                     t[c * 4 + w] = sb(s[((c + w) % 4) * 4 + w]);
               if (r < 14) begin
                  for (int c = 0; c < 4; c++) begin
                     a = t[c*4]; b = t[c*4+1]; c2 = t[c*4+2]; c3 = t[c*4+3];
                     all = a ^ b ^ c2 ^ c3;
                     t[c*4]   = a ^ all ^ dbl(a ^ b);
                     t[c*4+1] = b ^ all ^ dbl(b ^ c2);
                     t[c*4+2] = c2 ^ all ^ dbl(c2 ^ c3);
                     t[c*4+3] = c3 ^ all ^ dbl(c3 ^ a);
                  end
               end
               s = t;
            end
            for (int i = 0; i < 16; i++)
               s[i] ^= rk[r * 4 + i / 4][31 - 8 * (i % 4) -: 8];
         end
         return s[0];
      endfunction

      function void note_byte(input req_type q);
         rsp_type e;
         e.last_out = q.last_in_buffer;
         if (!keyed) begin
            e.out_byte = '0; e.status = 1'b1;
         end else begin
            e.out_byte = q.data_byte ^ keystream();
            e.status = 1'b0;
            for (int i = 0; i < 15; i++) fb[i] = fb[i + 1];
            fb[15] = decrypting ? q.data_byte : e.out_byte;
         end
         pending.push_back(e);
      endfunction

      task check_beat(input rsp_type got);
         rsp_type e;
         if (pending.size() == 0) begin
            report_mismatch("unexpected beat", got, 0);
            return;
         end
         e = pending.pop_front();
         if (got.out_byte !== e.out_byte) report_mismatch("out_byte", got.out_byte, e.out_byte);
         if (got.status !== e.status) report_mismatch("status", got.status, e.status);
         if (got.last_out !== e.last_out) report_mismatch("last_out", got.last_out, e.last_out);
      endtask
   endclass

   cfb8_scoreboard sb_model;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("FAIL aes256_cfb8_byte_cipher");
      $finish;
   end

   // Result side: random stall, with one long hold-off on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) sb_model.check_beat(rsp_data);
         rsp_stall <= long_hold || ($urandom_range(99) < mode_stall_pct);
      end
   end

   task automatic write_csr(input csr_reg_type idx, input logic [63:0] v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb_model.write_reg(idx, v);
      csr_valid <= 1'b0;
   endtask

   task automatic send_byte(input logic [7:0] d, input bit last);
      req_type q;
      while ($urandom_range(99) < mode_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      q.data_byte = d;
      q.last_in_buffer = last;
      req_valid <= 1'b1;
      req_data <= q;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb_model.note_byte(q);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb_model.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic load_key_iv(input logic [63:0] k0, k1, k2, k3, ih, il, input bit dec);
      write_csr(REG_KEY0, k0);
      write_csr(REG_KEY1, k1);
      write_csr(REG_KEY2, k2);
      write_csr(REG_KEY3, k3);
      write_csr(REG_IVH, ih);
      write_csr(REG_IVL, il);
      write_csr(REG_MODE, {63'd0, dec});
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   initial begin
      sb_model = new();
      sb_model.clear();
      error_count = 0;
      bytes_sent = 0;
      mode_idle_pct = 0;
      mode_stall_pct = 0;
      long_hold = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = REG_KEY0;
      csr_wdata = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Bytes before any key write must come back flagged and zero.
      send_byte(8'hff, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'h5a, 1'b1);
      drain();

      // All-zero and all-one keys, both modes, field extremes.
      load_key_iv('0, '0, '0, '0, '0, '0, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hff, 1'b1);
      send_byte(8'h80, 1'b0);
      send_byte(8'h01, 1'b1);
      drain();
      load_key_iv('1, '1, '1, '1, '1, '1, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'hff, 1'b1);
      send_byte(8'h3c, 1'b0);
      drain();
      // A mode write alone keeps the key schedule and the feedback state.
      write_csr(REG_MODE, 64'd0);
      send_byte(8'ha5, 1'b0);
      send_byte(8'h5a, 1'b1);
      drain();
      // Index beyond the register list is ignored.
      csr_valid <= 1'b1;
      csr_index <= 3'd7;
      csr_wdata <= rand64();
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      send_byte(8'h11, 1'b0);
      drain();

      // Random phases with fresh key or IV writes; each phase sets its idle and stall pattern.
      for (int ph = 0; ph < 12; ph++) begin
         case (ph % 4)
            0: begin mode_idle_pct = 0;  mode_stall_pct = 0;  end
            1: begin mode_idle_pct = 47; mode_stall_pct = 0;  end
            2: begin mode_idle_pct = 0;  mode_stall_pct = 47; end
            default: begin mode_idle_pct = 17; mode_stall_pct = 17; end
         endcase
         if (ph % 3 == 0)
            load_key_iv(rand64(), rand64(), rand64(), rand64(), rand64(), rand64(),
                        $urandom_range(1));
         else begin
            write_csr(csr_reg_type'($urandom_range(5)), rand64());
            write_csr(REG_MODE, {63'd0, 1'($urandom_range(1))});
         end
         if (ph == 5) begin
            fork
               begin
                  long_hold = 1;
                  repeat (300) @(posedge clock);
                  long_hold = 0;
               end
            join_none
         end
         for (int n = 0; n < 110; n++) begin
            send_byte(8'($urandom()), 1'($urandom_range(1)));
            bytes_sent++;
         end
         drain();
      end

      if (error_count == 0) begin
         $display("Covered: unkeyed bytes, extreme keys, %0d random bytes, both modes,",
                  bytes_sent);
         $display("ignored register index, and idle, stall and long hold-off phases.");
         $display("PASS aes256_cfb8_byte_cipher");
      end else begin
         $display("Covered run with %0d mismatches.", error_count);
         $display("FAIL aes256_cfb8_byte_cipher");
      end
      $finish;
   end
endmodule
`default_nettype wire
